@@ rtl/miq_pkg.sv @@
// Shared types, codes and ring-pointer helpers for the middle insertion queue.
// Used by middle_insertion_queue and its bench; depends on nothing.
`default_nettype none

package miq_pkg;

   localparam int CAPACITY = 1024;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int REQ_W    = 2;
   localparam int STAT_W   = 2;

   typedef logic [PTR_W-1:0]         ptr_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [REQ_W-1:0]         req_code_type;
   typedef logic [STAT_W-1:0]        status_type;

   localparam req_code_type REQ_APPEND = 2'd0;
   localparam req_code_type REQ_MIDDLE = 2'd1;
   localparam req_code_type REQ_POP    = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   localparam logic [CNT_W:0] CAP_WIDE = (CNT_W + 1)'(CAPACITY);
   localparam ptr_type        PTR_LAST = PTR_W'(CAPACITY - 1);

   // (p + o) mod CAPACITY; p < CAPACITY and o <= CAPACITY, so one subtract suffices
   function automatic ptr_type ring_add(ptr_type p, cnt_type o);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(p) + (CNT_W + 1)'(o);
      if (s >= CAP_WIDE) begin
         s = s - CAP_WIDE;
      end
      return s[PTR_W-1:0];
   endfunction

   function automatic ptr_type ring_inc(ptr_type p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic ptr_type ring_dec(ptr_type p);
      return (p == '0) ? PTR_LAST : p - 1'b1;
   endfunction

endpackage

`default_nettype wire

@@ rtl/middle_insertion_queue.sv @@
// Middle insertion queue: control, pointers and the two half-queue RAMs.
// Depends on miq_pkg and miq_ram.
//
// Usage
//   Request channel (req_valid / req_stall, req_type, req_value): append at tail,
//   insert at the middle, or pop the head. Result channel (rsp_valid / rsp_stall,
//   rsp_value_res, rsp_status) carries one word per pop and one per rejected push;
//   a successful push and the unused request code give no word.
//   The queue is split into a front half (ceil(n/2) oldest items) and a back half
//   deque, each a 1-read 1-write RAM with registered read data.
//   Steps per request:
//     append/middle with no rebalance, or moved straight to the front: on acceptance
//     append that rebalances: back RAM read, then front RAM write in S_MOVE
//     pop: front RAM read, then the result in S_POP (waits for a free output);
//       the back RAM rebalance read goes with it, its front write in S_POP
//     rejected push / pop on empty: status word from S_RES (waits for a free output)
//   One request is in work at a time; req_stall is high while it is.
//   A word waiting in the output register does not block a new request; only a
//   request that itself produces a word waits for the output register to free.
//   Reset (synchronous) empties the queue at once: no RAM clearing pass.
`default_nettype none

module middle_insertion_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire miq_pkg::req_code_type req_type,
   input  wire miq_pkg::data_type     req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output miq_pkg::data_type          rsp_value_res,
   output miq_pkg::status_type        rsp_status
);

   import miq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_MOVE = 2'd2;
   localparam logic [1:0] S_RES  = 2'd3;

   logic [1:0] state_ff, state_in;
   ptr_type    fh_ff, fh_in;      // front half head
   cnt_type    fc_ff, fc_in;      // front half count
   ptr_type    bh_ff, bh_in;      // back half head
   cnt_type    bc_ff, bc_in;      // back half count
   logic       mv_ff, mv_in;      // pop also owes a rebalance move
   status_type res_status_ff, res_status_in;

   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_value_ff, rsp_value_in;
   status_type rsp_status_ff, rsp_status_in;

   // RAM ports
   logic     f_we, f_re, b_we, b_re;
   ptr_type  f_wa, f_ra, b_wa, b_ra;
   data_type f_wd, b_wd;
   logic [DATA_W-1:0] f_rd, b_rd;

   logic accept, out_free, full;

   assign req_stall     = (state_ff != S_IDLE);
   assign accept        = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign full          = ((CNT_W + 1)'(fc_ff) + (CNT_W + 1)'(bc_ff)) >= CAP_WIDE;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      fh_in         = fh_ff;
      fc_in         = fc_ff;
      bh_in         = bh_ff;
      bc_in         = bc_ff;
      mv_in         = mv_ff;
      res_status_in = res_status_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      f_we = 1'b0;
      f_wa = ring_add(fh_ff, fc_ff);   // front tail
      f_wd = req_value;
      f_re = 1'b0;
      f_ra = fh_ff;
      b_we = 1'b0;
      b_wa = ring_add(bh_ff, bc_ff);   // back tail
      b_wd = req_value;
      b_re = 1'b0;
      b_ra = bh_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_APPEND, REQ_MIDDLE: begin
                     if (full) begin
                        res_status_in = ST_FULL;
                        state_in      = S_RES;
                     end else if (fc_ff <= bc_ff && (req_type == REQ_MIDDLE || bc_ff == '0)) begin
                        // new word would be the back head and move at once
                        f_we  = 1'b1;
                        fc_in = fc_ff + 1'b1;
                     end else if (req_type == REQ_MIDDLE) begin
                        b_we  = 1'b1;
                        b_wa  = ring_dec(bh_ff);
                        bh_in = ring_dec(bh_ff);
                        bc_in = bc_ff + 1'b1;
                     end else begin
                        b_we  = 1'b1;
                        bc_in = bc_ff + 1'b1;
                        if (fc_ff <= bc_ff) begin
                           // back head is an older word: fetch it
                           b_re     = 1'b1;
                           state_in = S_MOVE;
                        end
                     end
                  end
                  REQ_POP: begin
                     if (fc_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_RES;
                     end else begin
                        f_re     = 1'b1;
                        fh_in    = ring_inc(fh_ff);
                        fc_in    = fc_ff - 1'b1;
                        mv_in    = (fc_ff - 1'b1) < bc_ff;
                        b_re     = (fc_ff - 1'b1) < bc_ff;
                        state_in = S_POP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MOVE: begin
            f_we     = 1'b1;
            f_wd     = data_type'(b_rd);
            fc_in    = fc_ff + 1'b1;
            bh_in    = ring_inc(bh_ff);
            bc_in    = bc_ff - 1'b1;
            state_in = S_IDLE;
         end
         S_POP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = data_type'(f_rd);
               rsp_status_in = ST_OK;
               if (mv_ff) begin
                  f_we  = 1'b1;
                  f_wd  = data_type'(b_rd);
                  fc_in = fc_ff + 1'b1;
                  bh_in = ring_inc(bh_ff);
                  bc_in = bc_ff - 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_RES: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fh_ff        <= '0;
         fc_ff        <= '0;
         bh_ff        <= '0;
         bc_ff        <= '0;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fh_ff        <= fh_in;
         fc_ff        <= fc_in;
         bh_ff        <= bh_in;
         bc_ff        <= bc_in;
         mv_ff        <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   miq_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_front_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_wa),
      .wr_data (DATA_W'(f_wd)),
      .rd_en   (f_re),
      .rd_addr (f_ra),
      .rd_data (f_rd)
   );

   miq_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_back_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_wa),
      .wr_data (DATA_W'(b_wd)),
      .rd_en   (b_re),
      .rd_addr (b_ra),
      .rd_data (b_rd)
   );

   // front half holds ceil(n/2) whenever no request is in work
   a_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (fc_ff == bc_ff || fc_ff == bc_ff + 1'b1))
      else $error("halves out of balance");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W + 1)'(fc_ff) + (CNT_W + 1)'(bc_ff)) <= CAP_WIDE)
      else $error("occupancy above capacity");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_value_ff == '0))
      else $error("error word with nonzero value");

   a_pop_path: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_POP) |=> (state_ff == S_POP || state_ff == S_RES))
      else $error("pop did not start a result");

   a_move_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |=> (state_ff == S_IDLE))
      else $error("move state repeated");

endmodule

`default_nettype wire

@@ rtl/miq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
`default_nettype none

module miq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
